/* rtl/lja_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package lja_pkg;

  // fixed field and datapath widths
  localparam int IDX_W        = 6;
  localparam int D2_W         = 21;
  localparam int DEN_W        = 12;
  localparam int NX_W         = 16;
  localparam int QW           = 26;
  localparam int REM_W        = 13;
  localparam int PW           = 27;
  localparam int SQ_IN_W      = 56;
  localparam int SQ_RT_W      = 28;
  localparam int SQ_REM_W     = 31;
  localparam int CW           = 30;
  localparam int ZW           = 26;
  localparam int CORDIC_STEPS = 16;

  // register indexes
  localparam logic [1:0] REG_PPM    = 2'd0;
  localparam logic [1:0] REG_OFFSET = 2'd1;
  localparam logic [1:0] REG_LINK   = 2'd2;

  // register reset values
  localparam logic [6:0] PPM_RST    = 7'd5;
  localparam logic [7:0] OFFSET_RST = 8'd45;
  localparam logic [8:0] LINK_RST   = 9'd160;

  // fixed point constants, Q16
  localparam logic signed [PW-1:0] X_OFF_Q16  = 27'sd4915200;
  localparam logic signed [PW-1:0] Y_OFF_Q16  = 27'sd11468800;
  localparam logic signed [ZW-1:0] DEG90_Q16  = 26'sd5898240;
  localparam logic signed [ZW-1:0] DEG180_Q16 = 26'sd11796480;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             clip;
    logic             last;
  } tag_t;

  typedef struct packed {
    logic             vld;
    logic [9:0]       sx;
    logic [8:0]       sy;
    logic [9:0]       ex;
    logic [8:0]       ey;
    logic [IDX_W-1:0] wc;
    logic [IDX_W-1:0] wi;
    logic [DEN_W-1:0] den;
    tag_t             tag;
  } issue_t;

  typedef struct packed {
    logic        vld;
    logic [15:0] alpha;
    logic [15:0] beta;
    logic        reach;
    tag_t        tag;
  } result_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [QW-1:0]    q;
  } div_t;

  typedef struct packed {
    logic [SQ_REM_W-1:0] rem;
    logic [SQ_RT_W-1:0]  root;
    logic [SQ_IN_W-1:0]  v;
  } sq_t;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [ZW-1:0] z;
  } cst_t;

  // one restoring division step, quotient shifts in from the right
  function automatic div_t div_step(input div_t s, input logic [DEN_W-1:0] den);
    div_t o;
    logic [REM_W-1:0] r;
    r = {s.rem[REM_W-2:0], s.q[QW-1]};
    o.q = {s.q[QW-2:0], 1'b0};
    if (r >= {1'b0, den}) begin
      r = r - {1'b0, den};
      o.q[0] = 1'b1;
    end
    o.rem = r;
    return o;
  endfunction

  // one digit of the bitwise integer square root
  function automatic sq_t sqrt_step(input sq_t s);
    sq_t o;
    logic [SQ_REM_W-1:0] r2;
    logic [SQ_REM_W-1:0] t;
    r2 = {s.rem[SQ_REM_W-3:0], s.v[SQ_IN_W-1 -: 2]};
    t = {1'b0, s.root, 2'b01};
    o.v = {s.v[SQ_IN_W-3:0], 2'b00};
    if (r2 >= t) begin
      o.rem = r2 - t;
      o.root = {s.root[SQ_RT_W-2:0], 1'b1};
    end else begin
      o.rem = r2;
      o.root = {s.root[SQ_RT_W-2:0], 1'b0};
    end
    return o;
  endfunction

  // atan(2^-i) in degrees Q16
  function automatic logic [21:0] atan_q16(input int i);
    logic [21:0] a;
    case (i)
      0:       a = 22'd2949120;
      1:       a = 22'd1740967;
      2:       a = 22'd919879;
      3:       a = 22'd466945;
      4:       a = 22'd234379;
      5:       a = 22'd117304;
      6:       a = 22'd58666;
      7:       a = 22'd29335;
      8:       a = 22'd14668;
      9:       a = 22'd7334;
      10:      a = 22'd3667;
      11:      a = 22'd1833;
      12:      a = 22'd917;
      13:      a = 22'd458;
      14:      a = 22'd229;
      15:      a = 22'd115;
      default: a = 22'd0;
    endcase
    return a;
  endfunction

  // one vectoring step, floor shifts
  function automatic cst_t cordic_step(input cst_t s, input int i);
    cst_t o;
    logic signed [CW-1:0] xv, yv, sx, sy;
    logic signed [ZW-1:0] zv, at;
    xv = $signed(s.x);
    yv = $signed(s.y);
    zv = $signed(s.z);
    sx = yv >>> i;
    sy = xv >>> i;
    at = $signed(ZW'(atan_q16(i)));
    if (yv > 0) begin
      o.x = xv + sx;
      o.y = yv - sy;
      o.z = zv + at;
    end else begin
      o.x = xv - sx;
      o.y = yv + sy;
      o.z = zv - at;
    end
    return o;
  endfunction

  // clamp to 0..180 degrees and round to Q8.8
  function automatic logic [15:0] deg_q8(input logic [ZW-1:0] zin);
    logic signed [ZW-1:0] z;
    logic [23:0] zc;
    logic [24:0] s;
    z = $signed(zin);
    if (z < 0) zc = 24'd0;
    else if (z > DEG180_Q16) zc = 24'(DEG180_Q16);
    else zc = z[23:0];
    s = {1'b0, zc} + 25'd128;
    return s[23:8];
  endfunction

endpackage
`default_nettype wire

/* rtl/lja_dpath.sv */
`timescale 1ns / 1ps
`default_nettype none
module lja_dpath (
  input  logic            clk,
  input  logic            rst_n,
  input  lja_pkg::issue_t iss,
  input  logic [7:0]      base_offset,
  input  logic [8:0]      link_len,
  output lja_pkg::result_t res
);
  import lja_pkg::*;

  localparam int DIV_ST = QW / 2;
  localparam int SQ_ST  = SQ_IN_W / 4;
  localparam int CO_ST  = CORDIC_STEPS / 2;
  localparam int DEPTH  = 1 + DIV_ST + 3 + SQ_ST + 3 + SQ_ST + 1 + CO_ST + 1;

  // valid and tag delay line alongside the data stages
  logic [DEPTH-1:0] vl_r;
  tag_t             tl_r [DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vl_r <= '0;
    end else begin
      vl_r <= {vl_r[DEPTH-2:0], iss.vld};
    end
  end

  always_ff @(posedge clk) begin
    tl_r[0] <= iss.tag;
    for (int k = 1; k < DEPTH; k++) tl_r[k] <= tl_r[k-1];
  end

  // point pixel numerators
  logic [NX_W-1:0]  nx_r, ny_r;
  logic [DEN_W-1:0] den_a_r;

  always_ff @(posedge clk) begin
    nx_r    <= NX_W'(iss.sx) * NX_W'(iss.wc) + NX_W'(iss.ex) * NX_W'(iss.wi);
    ny_r    <= NX_W'(iss.sy) * NX_W'(iss.wc) + NX_W'(iss.ey) * NX_W'(iss.wi);
    den_a_r <= iss.den;
  end

  // rounded division to Q16 mm, two bits a stage
  logic [NX_W+16:0] nfx, nfy;
  div_t             dx0, dy0;
  div_t             dx_r [DIV_ST];
  div_t             dy_r [DIV_ST];
  logic [DEN_W-1:0] dd_r [DIV_ST];

  assign nfx = {1'b0, nx_r, 16'b0} + (NX_W+17)'(den_a_r >> 1);
  assign nfy = {1'b0, ny_r, 16'b0} + (NX_W+17)'(den_a_r >> 1);

  always_comb begin
    dx0.rem = REM_W'(nfx[NX_W+16:QW]);
    dx0.q   = nfx[QW-1:0];
    dy0.rem = REM_W'(nfy[NX_W+16:QW]);
    dy0.q   = nfy[QW-1:0];
  end

  always_ff @(posedge clk) begin
    dx_r[0] <= div_step(div_step(dx0, den_a_r), den_a_r);
    dy_r[0] <= div_step(div_step(dy0, den_a_r), den_a_r);
    dd_r[0] <= den_a_r;
    for (int k = 1; k < DIV_ST; k++) begin
      dx_r[k] <= div_step(div_step(dx_r[k-1], dd_r[k-1]), dd_r[k-1]);
      dy_r[k] <= div_step(div_step(dy_r[k-1], dd_r[k-1]), dd_r[k-1]);
      dd_r[k] <= dd_r[k-1];
    end
  end

  // mm coordinates and magnitudes
  logic signed [PW-1:0] pxv, pyv;
  logic signed [PW-1:0] px_r, pxd_r, pxe_r;
  logic [QW-1:0]        ax_r, ay_r, ayd_r, aye_r;
  logic [2*QW-1:0]      sqx_r, sqy_r;
  logic [2*QW:0]        rs_r;

  assign pxv = $signed({1'b0, dx_r[DIV_ST-1].q}) - X_OFF_Q16;
  assign pyv = Y_OFF_Q16 - $signed({1'b0, dy_r[DIV_ST-1].q});

  always_ff @(posedge clk) begin
    px_r  <= pxv;
    ax_r  <= (pxv < 0) ? QW'(-pxv) : QW'(pxv);
    ay_r  <= (pyv < 0) ? QW'(-pyv) : QW'(pyv);
    sqx_r <= ax_r * ax_r;
    sqy_r <= ay_r * ay_r;
    pxd_r <= px_r;
    ayd_r <= ay_r;
    rs_r  <= (2*QW+1)'(sqx_r) + (2*QW+1)'(sqy_r);
    pxe_r <= pxd_r;
    aye_r <= ayd_r;
  end

  // radius square root, two digits a stage
  sq_t                  s10;
  sq_t                  s1_r  [SQ_ST];
  logic signed [PW-1:0] s1x_r [SQ_ST];
  logic [QW-1:0]        s1y_r [SQ_ST];

  always_comb begin
    s10.rem  = '0;
    s10.root = '0;
    s10.v    = SQ_IN_W'(rs_r);
  end

  always_ff @(posedge clk) begin
    s1_r[0]  <= sqrt_step(sqrt_step(s10));
    s1x_r[0] <= pxe_r;
    s1y_r[0] <= aye_r;
    for (int k = 1; k < SQ_ST; k++) begin
      s1_r[k]  <= sqrt_step(sqrt_step(s1_r[k-1]));
      s1x_r[k] <= s1x_r[k-1];
      s1y_r[k] <= s1y_r[k-1];
    end
  end

  // offset radius, reach test, second root argument
  logic [SQ_RT_W-1:0]     rr;
  logic signed [SQ_RT_W:0] uv;
  logic [SQ_RT_W-1:0]     auv;
  logic [24:0]            lqv;

  assign rr  = s1_r[SQ_ST-1].root;
  assign uv  = $signed({1'b0, rr}) - $signed({5'b0, base_offset, 16'b0});
  assign auv = (uv < 0) ? SQ_RT_W'(-uv) : SQ_RT_W'(uv);
  assign lqv = {link_len, 16'b0};

  logic signed [SQ_RT_W:0] u_r, ug_r, uh_r;
  logic [SQ_RT_W-1:0]      au_r;
  logic [24:0]             lq_r;
  logic                    okf_r, okg_r, okh_r;
  logic signed [PW-1:0]    pxf_r, pxg_r, pxh_r;
  logic [QW-1:0]           ayf_r, ayg_r, ayh_r;
  logic [49:0]             lq2_r, dv_r;
  logic [2*SQ_RT_W-1:0]    au2_r;

  always_ff @(posedge clk) begin
    u_r   <= uv;
    au_r  <= auv;
    lq_r  <= lqv;
    okf_r <= (rr != '0) && (auv <= SQ_RT_W'(lqv));
    pxf_r <= s1x_r[SQ_ST-1];
    ayf_r <= s1y_r[SQ_ST-1];
    lq2_r <= lq_r * lq_r;
    au2_r <= au_r * au_r;
    ug_r  <= u_r;
    okg_r <= okf_r;
    pxg_r <= pxf_r;
    ayg_r <= ayf_r;
    dv_r  <= okg_r ? (lq2_r - au2_r[49:0]) : '0;
    uh_r  <= ug_r;
    okh_r <= okg_r;
    pxh_r <= pxg_r;
    ayh_r <= ayg_r;
  end

  // second square root
  sq_t                     s20;
  sq_t                     s2_r  [SQ_ST];
  logic signed [SQ_RT_W:0] s2u_r [SQ_ST];
  logic                    s2ok_r [SQ_ST];
  logic signed [PW-1:0]    s2x_r [SQ_ST];
  logic [QW-1:0]           s2y_r [SQ_ST];

  always_comb begin
    s20.rem  = '0;
    s20.root = '0;
    s20.v    = SQ_IN_W'(dv_r);
  end

  always_ff @(posedge clk) begin
    s2_r[0]   <= sqrt_step(sqrt_step(s20));
    s2u_r[0]  <= uh_r;
    s2ok_r[0] <= okh_r;
    s2x_r[0]  <= pxh_r;
    s2y_r[0]  <= ayh_r;
    for (int k = 1; k < SQ_ST; k++) begin
      s2_r[k]   <= sqrt_step(sqrt_step(s2_r[k-1]));
      s2u_r[k]  <= s2u_r[k-1];
      s2ok_r[k] <= s2ok_r[k-1];
      s2x_r[k]  <= s2x_r[k-1];
      s2y_r[k]  <= s2y_r[k-1];
    end
  end

  // cordic entry, left half plane turned by 90 degrees
  logic signed [CW-1:0] xa, ya, xb, yb;
  cst_t                 ca0, cb0;

  assign xa = CW'(s2x_r[SQ_ST-1]);
  assign ya = $signed(CW'(s2y_r[SQ_ST-1]));
  assign xb = CW'(s2u_r[SQ_ST-1]);
  assign yb = $signed(CW'(s2_r[SQ_ST-1].root));

  always_comb begin
    if (xa < 0) begin
      ca0.x = ya;
      ca0.y = -xa;
      ca0.z = DEG90_Q16;
    end else begin
      ca0.x = xa;
      ca0.y = ya;
      ca0.z = '0;
    end
    if (xb < 0) begin
      cb0.x = yb;
      cb0.y = -xb;
      cb0.z = DEG90_Q16;
    end else begin
      cb0.x = xb;
      cb0.y = yb;
      cb0.z = '0;
    end
  end

  // two vectoring steps a stage for both angles
  cst_t ca_r  [CO_ST+1];
  cst_t cb_r  [CO_ST+1];
  logic cok_r [CO_ST+1];

  always_ff @(posedge clk) begin
    ca_r[0]  <= ca0;
    cb_r[0]  <= cb0;
    cok_r[0] <= s2ok_r[SQ_ST-1];
    for (int k = 1; k <= CO_ST; k++) begin
      ca_r[k]  <= cordic_step(cordic_step(ca_r[k-1], 2*k-2), 2*k-1);
      cb_r[k]  <= cordic_step(cordic_step(cb_r[k-1], 2*k-2), 2*k-1);
      cok_r[k] <= cok_r[k-1];
    end
  end

  // output register
  logic [15:0] alpha_r, beta_r;
  logic        reach_r;

  always_ff @(posedge clk) begin
    alpha_r <= cok_r[CO_ST] ? deg_q8(ca_r[CO_ST].z) : 16'd0;
    beta_r  <= cok_r[CO_ST] ? deg_q8(cb_r[CO_ST].z) : 16'd0;
    reach_r <= cok_r[CO_ST];
  end

  always_comb begin
    res.vld   = vl_r[DEPTH-1];
    res.alpha = alpha_r;
    res.beta  = beta_r;
    res.reach = reach_r;
    res.tag   = tl_r[DEPTH-1];
  end

endmodule
`default_nettype wire

/* rtl/line_to_arm_joint_angles_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// while busy, a line goes through the segment count search (one length compare per
// cycle), one setup state, then one point issued per cycle
// the point pipeline is 58 stages deep and delivers one point per cycle, out_valid
// marks each beat
// rst_n is synchronous: clears the sequencer and valid bits, restores register defaults
module line_to_arm_joint_angles_core #(
  parameter int MAX_SEGMENTS = 63
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [9:0]  in_start_x,
  input  logic [8:0]  in_start_y,
  input  logic [9:0]  in_end_x,
  input  logic [8:0]  in_end_y,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  output logic        out_valid,
  output logic [15:0] out_alpha_deg,
  output logic [15:0] out_beta_deg,
  output logic        out_reachable,
  output logic [5:0]  out_point_index,
  output logic        out_count_clipped,
  output logic        out_last_point
);
  import lja_pkg::*;

  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int M_W   = $clog2((MAX_SEGMENTS + 1) * 128);
  localparam int CMP_W = (2 * M_W > D2_W) ? 2 * M_W : D2_W;

  typedef enum logic [1:0] {S_IDLE, S_COUNT, S_PREP, S_EMIT} state_t;

  // configuration registers
  logic [6:0] ppm_r;
  logic [7:0] offset_r;
  logic [8:0] link_r;
  logic [8:0] link_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ppm_r    <= PPM_RST;
      offset_r <= OFFSET_RST;
      link_r   <= LINK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PPM:    ppm_r    <= cfg_data[6:0];
        REG_OFFSET: offset_r <= cfg_data[7:0];
        REG_LINK:   link_r   <= cfg_data;
        default:    ;
      endcase
    end
  end

  assign link_eff = (link_r == '0) ? 9'd1 : link_r;

  // sequencer registers
  state_t           state_r, state_nxt;
  logic [9:0]       sx_r, sx_nxt, ex_r, ex_nxt;
  logic [8:0]       sy_r, sy_nxt, ey_r, ey_nxt;
  logic [6:0]       sppm_r, sppm_nxt;
  logic [D2_W-1:0]  d2_r, d2_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, idx_r, idx_nxt;
  logic [M_W-1:0]   m_r, m_nxt;
  logic             clip_r, clip_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;

  // squared line length
  logic [9:0]       adx;
  logic [8:0]       ady;
  logic [19:0]      adx2;
  logic [17:0]      ady2;
  logic [2*M_W-1:0] msq;
  logic             fits;
  logic [CNT_W-1:0] c_eff;

  assign adx   = (in_end_x >= in_start_x) ? in_end_x - in_start_x : in_start_x - in_end_x;
  assign ady   = (in_end_y >= in_start_y) ? in_end_y - in_start_y : in_start_y - in_end_y;
  assign adx2  = adx * adx;
  assign ady2  = ady * ady;
  assign msq   = m_r * m_r;
  assign fits  = CMP_W'(msq) <= CMP_W'(d2_r);
  assign c_eff = (cnt_r == '0) ? CNT_W'(1) : cnt_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    sx_nxt    = sx_r;
    sy_nxt    = sy_r;
    ex_nxt    = ex_r;
    ey_nxt    = ey_r;
    sppm_nxt  = sppm_r;
    d2_nxt    = d2_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    m_nxt     = m_r;
    clip_nxt  = clip_r;
    den_nxt   = den_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          sx_nxt    = in_start_x;
          sy_nxt    = in_start_y;
          ex_nxt    = in_end_x;
          ey_nxt    = in_end_y;
          sppm_nxt  = (ppm_r == '0) ? 7'd1 : ppm_r;
          d2_nxt    = D2_W'(adx2) + D2_W'(ady2);
          cnt_nxt   = '0;
          m_nxt     = M_W'((ppm_r == '0) ? 7'd1 : ppm_r);
          state_nxt = S_COUNT;
        end
      end
      S_COUNT: begin
        if (fits && cnt_r != CNT_W'(MAX_SEGMENTS)) begin
          cnt_nxt = cnt_r + CNT_W'(1);
          m_nxt   = m_r + M_W'(sppm_r);
        end else begin
          clip_nxt  = fits && (cnt_r == CNT_W'(MAX_SEGMENTS));
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        den_nxt   = DEN_W'(c_eff) * DEN_W'(sppm_r);
        idx_nxt   = '0;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (idx_r == cnt_r) begin
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    sx_r   <= sx_nxt;
    sy_r   <= sy_nxt;
    ex_r   <= ex_nxt;
    ey_r   <= ey_nxt;
    sppm_r <= sppm_nxt;
    d2_r   <= d2_nxt;
    cnt_r  <= cnt_nxt;
    idx_r  <= idx_nxt;
    m_r    <= m_nxt;
    clip_r <= clip_nxt;
    den_r  <= den_nxt;
  end

  assign busy = (state_r != S_IDLE);

  // one point into the pipeline per emit cycle
  issue_t  iss;
  result_t res;

  always_comb begin
    iss.vld      = (state_r == S_EMIT);
    iss.sx       = sx_r;
    iss.sy       = sy_r;
    iss.ex       = ex_r;
    iss.ey       = ey_r;
    iss.wc       = IDX_W'(c_eff - idx_r);
    iss.wi       = IDX_W'(idx_r);
    iss.den      = den_r;
    iss.tag.idx  = IDX_W'(idx_r);
    iss.tag.clip = clip_r;
    iss.tag.last = (idx_r == cnt_r);
  end

  lja_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .iss         (iss),
    .base_offset (offset_r),
    .link_len    (link_eff),
    .res         (res)
  );

  assign out_valid         = res.vld;
  assign out_alpha_deg     = res.alpha;
  assign out_beta_deg      = res.beta;
  assign out_reachable     = res.reach;
  assign out_point_index   = res.tag.idx;
  assign out_count_clipped = res.tag.clip;
  assign out_last_point    = res.tag.last;

endmodule
`default_nettype wire

/* rtl/lja_chk.sv */
`timescale 1ns / 1ps
`default_nettype none
module lja_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [9:0]  in_start_x,
  input logic [8:0]  in_start_y,
  input logic [9:0]  in_end_x,
  input logic [8:0]  in_end_y,
  input logic        cfg_we,
  input logic [1:0]  cfg_index,
  input logic [8:0]  cfg_data,
  input logic        out_valid,
  input logic [15:0] out_alpha_deg,
  input logic [15:0] out_beta_deg,
  input logic        out_reachable,
  input logic [5:0]  out_point_index,
  input logic        out_count_clipped,
  input logic        out_last_point
);

  // accepted line makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after accept");

  // points of one line come back to back in index order
  a_points_in_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_point_index != 6'd0 |->
      $past(out_valid) && ($past(out_point_index) + 6'd1 == out_point_index)
      && ($past(out_count_clipped) == out_count_clipped))
    else $error("point sequence broken");

  // a new line starts only after the last point of the previous one
  a_line_boundary: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_point_index == 6'd0 && $past(out_valid) |-> $past(out_last_point))
    else $error("line started before previous finished");

  // unreachable points carry zero angles
  a_unreach_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_reachable |-> out_alpha_deg == 16'd0 && out_beta_deg == 16'd0)
    else $error("angles not zero on unreachable point");

endmodule

bind line_to_arm_joint_angles_core lja_chk u_lja_chk (.*);
`default_nettype wire

/* tb/sv/tb_line_to_arm_joint_angles_core.sv */
`timescale 1ns / 1ps
module tb_line_to_arm_joint_angles_core;
  import lja_pkg::*;

  localparam int MAX_SEG = 63;
  localparam longint ONE = 65536;
  localparam longint DEG180_Q8 = 46080;
  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam longint ATAN_TBL [16] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115
  };

  typedef struct {
    bit          is_cfg;
    logic [1:0]  idx;
    logic [8:0]  data;
    logic [9:0]  sx;
    logic [8:0]  sy;
    logic [9:0]  ex;
    logic [8:0]  ey;
    int          max_gap;
  } line_req_t;

  typedef struct {
    logic [15:0] alpha;
    logic [15:0] beta;
    logic        reach;
    logic [5:0]  idx;
    logic        clip;
    logic        last;
  } point_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [9:0] in_start_x = '0;
  logic [8:0] in_start_y = '0;
  logic [9:0] in_end_x = '0;
  logic [8:0] in_end_y = '0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [8:0] cfg_data = '0;
  logic out_valid;
  logic [15:0] out_alpha_deg;
  logic [15:0] out_beta_deg;
  logic out_reachable;
  logic [5:0] out_point_index;
  logic out_count_clipped;
  logic out_last_point;

  line_req_t req_q[$];
  point_t    point_q[$];
  line_req_t cur_req;
  int        gap_left = 0;
  int        quiet_cycles = 0;
  int        err_count = 0;
  bit        stim_done = 0;

  // shadow copy of the registers
  logic [6:0] ppm_reg = PPM_RST;
  logic [7:0] offset_reg = OFFSET_RST;
  logic [8:0] link_reg = LINK_RST;

  always #1 clk = ~clk;

  line_to_arm_joint_angles_core dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_start_x(in_start_x), .in_start_y(in_start_y),
    .in_end_x(in_end_x), .in_end_y(in_end_y),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_alpha_deg(out_alpha_deg),
    .out_beta_deg(out_beta_deg), .out_reachable(out_reachable),
    .out_point_index(out_point_index), .out_count_clipped(out_count_clipped),
    .out_last_point(out_last_point)
  );

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // vectoring cordic, degrees q8.8 in 0..180
  function automatic logic [15:0] vector_angle(input longint xi, input longint yi);
    longint x, y, z, t, sx, sy;
    longint unsigned q;
    x = xi;
    y = yi;
    z = 0;
    if (x < 0) begin
      t = x;
      x = y;
      y = -t;
      z = 90 * ONE;
    end
    for (int i = 0; i < 16; i++) begin
      sx = y >>> i;
      sy = x >>> i;
      if (y > 0) begin
        x += sx;
        y -= sy;
        z += ATAN_TBL[i];
      end else begin
        x -= sx;
        y += sy;
        z -= ATAN_TBL[i];
      end
    end
    if (z < 0) z = 0;
    if (z > 180 * ONE) z = 180 * ONE;
    q = (z + 128) >> 8;
    if (q > DEG180_Q8) q = DEG180_Q8;
    return q[15:0];
  endfunction

  // joint angles of every point along one line
  task automatic predict_line_points(input line_req_t r);
    longint ppm, link, adx, ady, d2, cnt, c, den, nx, ny, xq, yq, ax, ay;
    longint rad, u, au, lq, s;
    bit clip;
    point_t p;
    ppm = (ppm_reg == 0) ? 1 : ppm_reg;
    link = (link_reg == 0) ? 1 : link_reg;
    adx = longint'(r.ex) - longint'(r.sx);
    ady = longint'(r.ey) - longint'(r.sy);
    d2 = adx * adx + ady * ady;
    cnt = 0;
    while (cnt < MAX_SEG && ((cnt + 1) * ppm) * ((cnt + 1) * ppm) <= d2) cnt++;
    clip = (cnt == MAX_SEG) && ((MAX_SEG + 1) * ppm) * ((MAX_SEG + 1) * ppm) <= d2;
    c = (cnt == 0) ? 1 : cnt;
    den = c * ppm;
    lq = link * ONE;
    for (longint i = 0; i <= cnt; i++) begin
      nx = longint'(r.sx) * (c - i) + longint'(r.ex) * i;
      ny = longint'(r.sy) * (c - i) + longint'(r.ey) * i;
      xq = (nx * ONE + den / 2) / den - 75 * ONE;
      yq = 175 * ONE - (ny * ONE + den / 2) / den;
      ax = xq < 0 ? -xq : xq;
      ay = yq < 0 ? -yq : yq;
      rad = int_sqrt(ax * ax + ay * ay);
      u = rad - longint'(offset_reg) * ONE;
      au = u < 0 ? -u : u;
      p.alpha = '0;
      p.beta = '0;
      p.reach = 1'b0;
      if (rad > 0 && au <= lq) begin
        s = int_sqrt(lq * lq - au * au);
        p.alpha = vector_angle(xq, ay);
        p.beta = vector_angle(u, s);
        p.reach = 1'b1;
      end
      p.idx = i[5:0];
      p.clip = clip;
      p.last = (i == cnt);
      point_q.insert(point_q.size(), p);
    end
  endtask

  // driver: lines and register writes from the request queue
  always @(posedge clk) begin
    bit nxt_start;
    bit nxt_we;
    nxt_start = start;
    nxt_we = 1'b0;
    if (!rst_n) begin
      nxt_start = 1'b0;
    end else begin
      if (start && !busy) begin
        predict_line_points(cur_req);
        nxt_start = 1'b0;
        gap_left = $urandom_range(0, cur_req.max_gap);
      end
      if (!nxt_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (req_q.size() > 0) begin
          if (req_q[0].is_cfg) begin
            // registers change only once the block has drained
            if (point_q.size() == 0 && !busy && quiet_cycles >= 8 && !start) begin
              cur_req = req_q.pop_front();
              nxt_we = 1'b1;
              cfg_index <= cur_req.idx;
              cfg_data <= cur_req.data;
              case (cur_req.idx)
                REG_PPM:    ppm_reg = cur_req.data[6:0];
                REG_OFFSET: offset_reg = cur_req.data[7:0];
                REG_LINK:   link_reg = cur_req.data;
                default:    ;
              endcase
            end
          end else begin
            cur_req = req_q.pop_front();
            in_start_x <= cur_req.sx;
            in_start_y <= cur_req.sy;
            in_end_x <= cur_req.ex;
            in_end_y <= cur_req.ey;
            nxt_start = 1'b1;
          end
        end
      end
    end
    start <= nxt_start;
    cfg_we <= nxt_we;
  end

  // monitor: each result beat against the oldest expected point
  always @(posedge clk) begin
    point_t e;
    if (!rst_n || out_valid || start) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (rst_n && out_valid) begin
      if (point_q.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        e = point_q.pop_front();
        if (out_alpha_deg !== e.alpha)
          report_mismatch($sformatf("alpha %0d exp %0d", out_alpha_deg, e.alpha));
        if (out_beta_deg !== e.beta)
          report_mismatch($sformatf("beta %0d exp %0d", out_beta_deg, e.beta));
        if (out_reachable !== e.reach)
          report_mismatch($sformatf("reachable %0b exp %0b", out_reachable, e.reach));
        if (out_point_index !== e.idx)
          report_mismatch($sformatf("index %0d exp %0d", out_point_index, e.idx));
        if (out_count_clipped !== e.clip)
          report_mismatch($sformatf("clipped %0b exp %0b", out_count_clipped, e.clip));
        if (out_last_point !== e.last)
          report_mismatch($sformatf("last %0b exp %0b", out_last_point, e.last));
      end
    end
  end

  task automatic add_cfg(input logic [1:0] idx, input logic [8:0] data);
    line_req_t r;
    r = '{default: '0};
    r.is_cfg = 1;
    r.idx = idx;
    r.data = data;
    req_q.insert(req_q.size(), r);
  endtask

  task automatic add_line(input int sx, input int sy, input int ex, input int ey,
                          input int max_gap);
    line_req_t r;
    r = '{default: '0};
    r.sx = 10'(sx);
    r.sy = 9'(sy);
    r.ex = 10'(ex);
    r.ey = 9'(ey);
    r.max_gap = max_gap;
    req_q.insert(req_q.size(), r);
  endtask

  // random lines: mostly short, some spanning the whole screen
  task automatic add_random_lines(input int n, input int max_gap);
    int sx, sy, ex, ey;
    for (int k = 0; k < n; k++) begin
      sx = $urandom_range(0, 1023);
      sy = $urandom_range(0, 511);
      if ($urandom_range(0, 3) == 0) begin
        ex = $urandom_range(0, 1023);
        ey = $urandom_range(0, 511);
      end else begin
        ex = sx + $signed($urandom_range(0, 80)) - 40;
        ey = sy + $signed($urandom_range(0, 80)) - 40;
        ex = ex < 0 ? 0 : (ex > 1023 ? 1023 : ex);
        ey = ey < 0 ? 0 : (ey > 511 ? 511 : ey);
      end
      add_line(sx, sy, ex, ey, max_gap);
    end
  endtask

  initial begin
    // directed: zero length, extremes, axis lines, arm origin, clipping
    add_line(0, 0, 0, 0, 0);
    add_line(1023, 511, 1023, 511, 2);
    add_line(0, 0, 1023, 511, 0);
    add_line(1023, 511, 0, 0, 5);
    add_line(100, 200, 400, 200, 0);
    add_line(375, 0, 375, 511, 3);
    add_line(375, 100, 376, 100, 0);
    add_cfg(REG_PPM, 9'd2);
    add_line(150, 350, 150, 350, 0);
    add_line(140, 350, 160, 350, 0);
    add_cfg(REG_PPM, 9'd1);
    add_cfg(REG_OFFSET, 9'd255);
    add_cfg(REG_LINK, 9'd1);
    add_line(0, 0, 1023, 511, 1);
    add_line(75, 0, 75, 175, 0);
    add_cfg(REG_PPM, 9'd64);
    add_cfg(REG_OFFSET, 9'd0);
    add_cfg(REG_LINK, 9'd511);
    add_line(0, 511, 1023, 0, 0);
    add_line(4800, 0, 4800, 0, 0);
    add_cfg(REG_UNUSED, 9'h1ff);
    add_cfg(REG_PPM, 9'd0);
    add_cfg(REG_LINK, 9'd0);
    add_line(0, 0, 100, 0, 0);
    add_line(1023, 0, 1023, 511, 4);

    // random phases over several register settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin add_cfg(REG_PPM, 9'd5); add_cfg(REG_OFFSET, 9'd45);
                 add_cfg(REG_LINK, 9'd160); end
        1: begin add_cfg(REG_PPM, 9'd1); add_cfg(REG_LINK, 9'd511); end
        2: begin add_cfg(REG_PPM, 9'd127); add_cfg(REG_OFFSET, 9'd255); end
        3: begin add_cfg(REG_PPM, 9'd64); add_cfg(REG_OFFSET, 9'd0);
                 add_cfg(REG_LINK, 9'd1); end
        4: begin add_cfg(REG_PPM, 9'd3); add_cfg(REG_OFFSET, 9'd170);
                 add_cfg(REG_LINK, 9'd300); end
        default: begin
          add_cfg(REG_PPM, 9'($urandom_range(1, 127)));
          add_cfg(REG_OFFSET, 9'($urandom_range(0, 255)));
          add_cfg(REG_LINK, 9'($urandom_range(1, 511)));
        end
      endcase
      add_random_lines(54, (ph % 3 == 1) ? 0 : 12);
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (req_q.size() > 0 || start || point_q.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (err_count == 0 && point_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
